// ----- design/mspi_pkg.sv -----
// Package: constants, types and command/status structs for the PI speed controller.
package mspi_pkg;

  localparam int NUM_MOTORS = 3;
  localparam int FRAC_BITS  = 12;
  localparam int NUM_SP_REGS = 3;

  localparam logic [15:0] SPEED_MAX = 16'd32767;
  localparam int KP_RUN  = 35;
  localparam int KP_STOP = 70;

  // measured speed numerator: 1e8 << FRAC_BITS (fits 40 bits at FRAC_BITS = 12)
  localparam int SPD_NUM_W = 44;
  localparam logic [SPD_NUM_W-1:0] SPD_NUM = 44'(64'd100000000 << FRAC_BITS);
  localparam logic [15:0] SPD_SCALE = 16'd17475;
  localparam int SPD_DEN_W = 47;   // 17475 * 2^32 fits in 47 bits

  // drive quotient widths
  localparam int DRV_NUM_W = 72;   // magnitude of Kp*e*D + 72*2^F*sum
  localparam int DRV_DEN_W = 36;   // 2^F * D

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPD_DIV,
    ST_ERR,
    ST_MUL,
    ST_DRV_DIV,
    ST_OUT
  } mspi_state_t;

  typedef struct packed {
    logic load;       // capture input beat
    logic spd_start;  // start speed division
    logic err;        // form error and integrator
    logic mul;        // drive numerator/denominator step; the datapath does not use it
    logic drv_start;  // start drive division
    logic finish;     // finish result into output register
  } mspi_cmd_t;

  typedef struct packed {
    logic div_done;
  } mspi_stat_t;

endpackage

// ----- design/mspi_ctrl.sv -----
// Controller state machine sequencing the speed and drive divisions.
module mspi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               out_free,
  input  mspi_pkg::mspi_stat_t stat,
  output mspi_pkg::mspi_cmd_t  cmd,
  output logic               busy
);
  import mspi_pkg::*;

  mspi_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_fire) state_next = ST_SPD_DIV;
      ST_SPD_DIV: if (stat.div_done) state_next = ST_ERR;
      ST_ERR:     state_next = ST_MUL;
      ST_MUL:     state_next = ST_DRV_DIV;
      ST_DRV_DIV: if (stat.div_done) state_next = ST_OUT;
      ST_OUT:     if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
        cmd.spd_start = in_fire;
      end
      ST_SPD_DIV: ;
      ST_ERR:     cmd.err = 1'b1;
      ST_MUL: begin
        cmd.mul = 1'b1;
        cmd.drv_start = 1'b1;
      end
      ST_DRV_DIV: ;
      ST_OUT:     cmd.finish = out_free;
      default:    ;
    endcase
  end
endmodule

// ----- design/mspi_datapath.sv -----
// Datapath: setpoint registers, integrators, shared serial divider, drive result.
module mspi_datapath (
  input  logic               clk,
  input  logic               rst,
  input  mspi_pkg::mspi_cmd_t  cmd,
  output mspi_pkg::mspi_stat_t stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [15:0]        cfg_data,
  output logic [15:0]        cfg_rdata,
  input  logic [1:0]         cfg_ridx,
  input  logic [1:0]         in_sel,
  input  logic [31:0]        in_count,
  input  logic               in_ccw,
  output logic [1:0]         res_idx,
  output logic [15:0]        res_drive,
  output logic               res_rev,
  output logic               res_sat
);
  import mspi_pkg::*;

  logic signed [15:0] setpoint [NUM_MOTORS];
  logic signed [31:0] integ [NUM_MOTORS];

  logic [1:0]  idx;
  logic [31:0] count;
  logic        ccw;
  logic signed [15:0] sp;
  logic [15:0] m;
  logic        clip;
  logic signed [18:0] e;
  logic signed [31:0] sum;
  logic        neg;

  // shared restoring divider
  logic [DRV_NUM_W-1:0] dv_rem_q;  // quotient shifts in from the bottom
  logic [DRV_DEN_W+12:0] dv_acc;
  logic [DRV_DEN_W+11:0] dv_den;
  logic [6:0]  dv_cnt;
  logic        dv_run;
  logic        dv_spd;

  // speed divisor uses upper region; remainder width covers both cases
  logic [DRV_DEN_W+12:0] acc_sh;
  logic [DRV_DEN_W+12:0] acc_sub;

  assign acc_sh  = {dv_acc[DRV_DEN_W+11:0], dv_rem_q[DRV_NUM_W-1]};
  assign acc_sub = acc_sh - {1'b0, dv_den};
  assign stat.div_done = dv_run && (dv_cnt == 7'd0);

  // speed quotient clamps
  logic [15:0] m_val;
  logic        m_clip;
  always_comb begin
    if (count == 32'd0 || dv_rem_q[SPD_NUM_W-1:15] != '0) begin
      m_val = SPEED_MAX; m_clip = 1'b1;
    end else begin
      m_val = {1'b0, dv_rem_q[14:0]}; m_clip = 1'b0;
    end
  end

  // error and integrator
  logic signed [18:0] r, e_c;
  logic signed [32:0] s_wide;
  logic signed [31:0] s_sat;
  logic        s_clip;
  always_comb begin
    r = (sp < 0) ? -19'(sp) : 19'(sp);
    if (sp > 0) e_c = ccw ? r + 19'(m) : r - 19'(m);
    else        e_c = ccw ? 19'(m) - r : -r - 19'(m);
    s_wide = 33'(integ[idx]) + 33'(e_c);
    s_clip = 1'b0;
    s_sat = s_wide[31:0];
    if (s_wide > 33'sh0_7FFF_FFFF) begin s_sat = 32'h7FFF_FFFF; s_clip = 1'b1; end
    else if (s_wide < -33'sh0_8000_0000) begin s_sat = 32'h8000_0000; s_clip = 1'b1; end
  end

  // drive numerator: Kp*e*D + 72*2^F*sum, or Kp*e at zero sp (combinational)
  logic signed [19:0] d_c;
  logic signed [63:0] nume;
  logic [DRV_NUM_W-1:0] num_mag;
  always_comb begin
    d_c  = 20'(r) * 20'sd2 + 20'(11 << FRAC_BITS);
    nume = 64'(KP_RUN) * 64'(e) * 64'(d_c) + 64'(72 << FRAC_BITS) * 64'(sum);
    if (sp == 0) nume = 64'(KP_STOP) * 64'(e);
    num_mag = (nume < 0) ? DRV_NUM_W'(-nume) : DRV_NUM_W'(nume);
  end

  logic [DRV_DEN_W-1:0] den_c;
  always_comb den_c = (sp == 0) ? DRV_DEN_W'(1 << FRAC_BITS)
                                : DRV_DEN_W'(d_c) << FRAC_BITS;

  // drive finish
  logic [15:0] drv;
  logic        d_clip;
  always_comb begin
    d_clip = 1'b0;
    drv = 16'd0;
    if (!neg) begin
      if (dv_rem_q > DRV_NUM_W'(32767)) begin drv = 16'h7FFF; d_clip = 1'b1; end
      else drv = dv_rem_q[15:0];
    end else begin
      if (dv_rem_q > DRV_NUM_W'(32768)) begin drv = 16'h8000; d_clip = 1'b1; end
      else drv = 16'(-dv_rem_q[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_run <= 1'b0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        setpoint[i] <= '0;
        integ[i] <= '0;
      end
    end else begin
      if (cfg_we && 32'(cfg_idx) < NUM_SP_REGS && 32'(cfg_idx) < NUM_MOTORS)
        setpoint[cfg_idx] <= cfg_data;
      if (cmd.spd_start) begin
        dv_run <= 1'b1;
        dv_spd <= 1'b1;
        dv_cnt <= 7'(SPD_NUM_W);
        dv_acc <= '0;
        dv_rem_q <= {SPD_NUM, (DRV_NUM_W-SPD_NUM_W)'(0)};
        dv_den <= (DRV_DEN_W+12)'(SPD_SCALE) * (DRV_DEN_W+12)'(in_count);
      end else if (cmd.drv_start) begin
        dv_run <= 1'b1;
        dv_spd <= 1'b0;
        dv_cnt <= 7'(DRV_NUM_W);
        dv_acc <= '0;
        dv_rem_q <= num_mag;
        dv_den <= (DRV_DEN_W+12)'(den_c);
        neg <= nume < 0;
      end else if (dv_run) begin
        if (dv_cnt == 7'd0) dv_run <= 1'b0;
        else begin
          dv_cnt <= dv_cnt - 7'd1;
          if (!acc_sub[DRV_DEN_W+12]) begin
            dv_acc <= acc_sub;
            dv_rem_q <= {dv_rem_q[DRV_NUM_W-2:0], 1'b1};
          end else begin
            dv_acc <= acc_sh;
            dv_rem_q <= {dv_rem_q[DRV_NUM_W-2:0], 1'b0};
          end
        end
      end
      if (cmd.err) begin
        integ[idx] <= s_sat;
        sum <= s_sat;
        e <= e_c;
        clip <= m_clip | s_clip;
      end
      if (cmd.finish) begin
        res_idx <= idx;
        res_drive <= drv;
        res_rev <= sp[15];
        res_sat <= clip | d_clip;
      end
    end
    if (cmd.load) begin
      idx <= in_sel;
      count <= in_count;
      ccw <= in_ccw;
      sp <= setpoint[in_sel];
    end
    if (dv_spd && stat.div_done) m <= m_val;
  end

  assign cfg_rdata = (32'(cfg_ridx) < NUM_MOTORS) ? setpoint[cfg_ridx] : 16'd0;
endmodule

// ----- design/motor_speed_pi_controller_top.sv -----
// Top level: three-motor PI speed controller with stream and APB ports.
//
//  channel   dir  beat contents
//  s_axis    in   tdata = motor_select[1:0], period_count[33:2], measured_ccw[34]
//  m_axis    out  tdata = motor_index[1:0], drive_value[17:2], reverse_command[18],
//                         saturated[19]
//  apb       in   setpoints of motors 0..2 at byte addresses 0, 4, 8
//
// The two restoring divisions share one divider and run in turn: the speed
// division (44 steps), the error and integrator step, the drive numerator, the
// drive division (72 steps) and the output load. Input is blocked from an accepted
// beat until its result is loaded. Reset clears integrators and setpoints.
// The result waits in the output register; a stalled master side holds the
// following result in the controller and blocks input until the register is free.
// Beats for motor 3 are dropped with no result.
module motor_speed_pi_controller_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // motor_select, period_count, measured_ccw
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // motor_index, drive_value, reverse_command, saturated
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mspi_pkg::*;

  mspi_cmd_t  cmd;
  mspi_stat_t stat;
  logic busy, in_fire, valid_sel;
  logic [1:0] r_idx;
  logic [15:0] r_drv;
  logic r_rev, r_sat, out_full;
  logic [15:0] rdata16;

  assign valid_sel = 32'(s_axis_tdata[1:0]) < NUM_MOTORS;
  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready && valid_sel;
  assign pready = 1'b1;

  mspi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(!out_full),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  mspi_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(psel && penable && pwrite && pready),
    .cfg_idx(paddr[3:2]), .cfg_data(pwdata[15:0]),
    .cfg_rdata(rdata16), .cfg_ridx(paddr[3:2]),
    .in_sel(s_axis_tdata[1:0]), .in_count(s_axis_tdata[33:2]), .in_ccw(s_axis_tdata[34]),
    .res_idx(r_idx), .res_drive(r_drv), .res_rev(r_rev), .res_sat(r_sat)
  );

  // output register flag: set on finish, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (cmd.finish) out_full <= 1'b1;
    else if (m_axis_tready) out_full <= 1'b0;
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {4'd0, r_sat, r_rev, r_drv, r_idx};
  assign prdata = {{16{rdata16[15]}}, rdata16};
endmodule

// ----- design/mspi_checker.sv -----
// Port checker for the PI speed controller, bound to the top level.
module mspi_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_sel,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped while stalled");
  a_idx: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("bad motor index");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_sel != 2'd3 |=> !s_axis_tready)
    else $error("input still ready while a tick is in work");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:20] == 4'd0)
    else $error("pad bits set");
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");
endmodule

bind motor_speed_pi_controller_top mspi_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_sel(s_axis_tdata[1:0]),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
